/* src/imh_pkg.sv */
package imh_pkg;

	// Request kinds
	localparam logic [2:0] KIND_INSERT = 3'd0;
	localparam logic [2:0] KIND_UPDATE = 3'd1;
	localparam logic [2:0] KIND_EXTRACT = 3'd2;
	localparam logic [2:0] KIND_FINAL = 3'd3;
	localparam logic [2:0] KIND_CLEAR = 3'd4;

	// Response codes
	localparam logic [1:0] CODE_OK = 2'd0;
	localparam logic [1:0] CODE_EMPTY = 2'd1;
	localparam logic [1:0] CODE_UNREACH = 2'd2;
	localparam logic [1:0] CODE_REJECT = 2'd3;

	localparam logic signed [31:0] KEY_INF = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [2:0] kind;
		logic [11:0] item;
		logic signed [31:0] key;
	} req_t;

	typedef struct packed {
		logic [11:0] out_item;
		logic signed [31:0] out_key;
		logic [1:0] code;
		logic [12:0] occupancy;
	} rsp_t;

	// One heap slot: the item and its key
	typedef struct packed {
		logic [11:0] item;
		logic signed [31:0] key;
	} heap_ent_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		DP_NONE,
		DP_ACCEPT,
		DP_REJECT,
		DP_INS_START,
		DP_UPD_START,
		DP_FIN_MARK,
		DP_EMPTY,
		DP_EX_START,
		DP_UP_RD,
		DP_UP_MOVE,
		DP_DN_RD,
		DP_DN_MOVE,
		DP_PLACE,
		DP_CLR_START,
		DP_CLR_STEP,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic item_ok;
		logic map_unseen;
		logic map_inheap;
		logic cnt_full;
		logic cnt_zero;
		logic ex_last;
		logic s_zero;
		logic up_less;
		logic dn_child;
		logic dn_less;
		logic clr_last;
		logic out_free;
	} dp_stat_t;

endpackage

/* src/indexed_min_heap_with_finalize_top.sv */
// Indexed binary min-heap with finalize marks (shortest-path frontier).
// Request channel req/req_valid/req_stall carries kind, item and key; the
// response channel rsp/rsp_valid/rsp_stall returns one transaction per
// request: removed or echoed item, key, status code and heap occupancy.
// Reject, finalize, empty extract and extract of the only queued item go
// from the check straight to the response; sift-up and extract walk the heap
// one level per read and compare, then place the moving entry (an insert into
// 4096 items can climb twelve levels, each a heap read then a compare).
// Clear sweeps the position map, one entry a cycle.
// One request is worked on at a time; req_stall is low only while idle.
// After reset the block runs the same sweep over all ITEMS entries of the
// position map, with req_stall high, before taking its first transaction.
// A finished response waits in the output register while rsp_stall is
// high; the block meanwhile accepts and works on the next request and
// holds its own response until the register is free.
module indexed_min_heap_with_finalize_top #(
	parameter int ITEMS = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input imh_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output imh_pkg::rsp_t rsp
);
	import imh_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;

	imh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.stat(stat), .cmd(cmd)
	);

	imh_dp #(.ITEMS(ITEMS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);
endmodule

/* src/imh_ram.sv */
module imh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic wr_en,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

/* src/imh_dp.sv */
module imh_dp #(
	parameter int ITEMS = 4096
) (
	input logic clk,
	input logic arst_n,
	input imh_pkg::dp_cmd_t cmd,
	output imh_pkg::dp_stat_t stat,
	input imh_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output imh_pkg::rsp_t rsp
);
	import imh_pkg::*;

	localparam int AW = (ITEMS > 1) ? $clog2(ITEMS) : 1;
	localparam int CW = $clog2(ITEMS + 1);
	localparam int MW = $clog2(ITEMS + 2);
	localparam logic [MW-1:0] MAP_UNSEEN = MW'(0);
	localparam logic [MW-1:0] MAP_FINAL = MW'(1);
	localparam logic [MW-1:0] MAP_BASE = MW'(2);

	logic [2:0] kind_q;
	logic [11:0] item_q;
	logic signed [31:0] key_q;
	logic [AW-1:0] s_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] clr_q;
	heap_ent_t mv_q;
	logic [11:0] res_item_q;
	logic signed [31:0] res_key_q;
	logic [1:0] res_code_q;
	logic out_valid_q;
	rsp_t out_q;

	heap_ent_t ha_rd, hb_rd, chosen;
	logic [MW-1:0] map_rd;
	logic [AW-1:0] ha_raddr, hb_raddr, map_raddr;
	logic heap_we, map_we;
	logic [AW-1:0] heap_waddr, map_waddr;
	heap_ent_t heap_wdata;
	logic [MW-1:0] map_wdata, s_map;
	logic [AW-1:0] parent;
	logic [AW:0] c_w, c1_w, cnt_w;
	logic pick_b;

	// Slot arithmetic
	assign parent = AW'((s_q - AW'(1)) >> 1);
	assign c_w = {s_q, 1'b1};
	assign c1_w = c_w + (AW + 1)'(1);
	assign cnt_w = (AW + 1)'(cnt_q);
	assign s_map = MW'(s_q) + MAP_BASE;
	assign pick_b = (c1_w < cnt_w) && ($signed(hb_rd.key) < $signed(ha_rd.key));
	assign chosen = pick_b ? hb_rd : ha_rd;

	// Read address selection
	always_comb begin
		ha_raddr = '0;
		hb_raddr = '0;
		map_raddr = AW'(req.item);
		case (cmd.op)
			DP_ACCEPT: begin
				ha_raddr = '0;
				hb_raddr = AW'(cnt_q - CW'(1));
			end
			DP_UP_RD: ha_raddr = parent;
			DP_DN_RD: begin
				ha_raddr = AW'(c_w);
				hb_raddr = AW'(c1_w);
			end
			default: ;
		endcase
	end

	// Write port selection
	always_comb begin
		heap_we = 1'b0;
		heap_waddr = s_q;
		heap_wdata = mv_q;
		map_we = 1'b0;
		map_waddr = AW'(mv_q.item);
		map_wdata = s_map;
		case (cmd.op)
			DP_UP_MOVE: begin
				heap_we = 1'b1;
				heap_wdata = ha_rd;
				map_we = 1'b1;
				map_waddr = AW'(ha_rd.item);
			end
			DP_DN_MOVE: begin
				heap_we = 1'b1;
				heap_wdata = chosen;
				map_we = 1'b1;
				map_waddr = AW'(chosen.item);
			end
			DP_PLACE: begin
				heap_we = 1'b1;
				map_we = 1'b1;
			end
			DP_EX_START: begin
				map_we = 1'b1;
				map_waddr = AW'(ha_rd.item);
				map_wdata = (ha_rd.key == KEY_INF) ? MAP_UNSEEN : MAP_FINAL;
			end
			DP_FIN_MARK: begin
				map_we = 1'b1;
				map_waddr = AW'(item_q);
				map_wdata = MAP_FINAL;
			end
			DP_CLR_STEP: begin
				map_we = 1'b1;
				map_waddr = clr_q;
				map_wdata = MAP_UNSEEN;
			end
			default: ;
		endcase
	end

	// Two copies of the heap so both children read in the same cycle
	imh_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(ITEMS)) u_heap_a (
		.clk(clk), .wr_en(heap_we), .wr_addr(heap_waddr), .wr_data(heap_wdata),
		.rd_addr(ha_raddr), .rd_data(ha_rd)
	);
	imh_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(ITEMS)) u_heap_b (
		.clk(clk), .wr_en(heap_we), .wr_addr(heap_waddr), .wr_data(heap_wdata),
		.rd_addr(hb_raddr), .rd_data(hb_rd)
	);
	imh_ram #(.WIDTH(MW), .DEPTH(ITEMS)) u_map (
		.clk(clk), .wr_en(map_we), .wr_addr(map_waddr), .wr_data(map_wdata),
		.rd_addr(map_raddr), .rd_data(map_rd)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == DP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				DP_INS_START: cnt_q <= cnt_q + CW'(1);
				DP_EX_START: cnt_q <= cnt_q - CW'(1);
				DP_CLR_START: begin
					cnt_q <= '0;
					clr_q <= '0;
				end
				DP_CLR_STEP: clr_q <= (clr_q == AW'(ITEMS - 1)) ? '0 : clr_q + AW'(1);
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_ACCEPT: begin
				kind_q <= req.kind;
				item_q <= req.item;
				key_q <= req.key;
				res_item_q <= req.item;
				res_key_q <= '0;
				res_code_q <= CODE_OK;
			end
			DP_REJECT: res_code_q <= CODE_REJECT;
			DP_EMPTY: begin
				res_item_q <= '0;
				res_code_q <= CODE_EMPTY;
			end
			DP_INS_START: begin
				s_q <= AW'(cnt_q);
				mv_q <= '{item: item_q, key: key_q};
			end
			DP_UPD_START: begin
				s_q <= AW'(map_rd - MAP_BASE);
				mv_q <= '{item: item_q, key: key_q};
			end
			DP_EX_START: begin
				res_item_q <= ha_rd.item;
				res_key_q <= ha_rd.key;
				res_code_q <= (ha_rd.key == KEY_INF) ? CODE_UNREACH : CODE_OK;
				mv_q <= hb_rd;
				s_q <= '0;
			end
			DP_UP_MOVE: s_q <= parent;
			DP_DN_MOVE: s_q <= pick_b ? AW'(c1_w) : AW'(c_w);
			DP_OUT: begin
				out_q.out_item <= res_item_q;
				out_q.out_key <= res_key_q;
				out_q.code <= res_code_q;
				out_q.occupancy <= 13'(cnt_q);
			end
			default: ;
		endcase
	end

	// Status to the controller
	always_comb begin
		stat.kind = kind_q;
		stat.item_ok = (32'(item_q) < 32'(ITEMS));
		stat.map_unseen = (map_rd == MAP_UNSEEN);
		stat.map_inheap = (map_rd >= MAP_BASE);
		stat.cnt_full = (cnt_q >= CW'(ITEMS));
		stat.cnt_zero = (cnt_q == '0);
		stat.ex_last = (cnt_q == CW'(1));
		stat.s_zero = (s_q == '0);
		stat.up_less = ($signed(mv_q.key) < $signed(ha_rd.key));
		stat.dn_child = (c_w < cnt_w);
		stat.dn_less = ($signed(chosen.key) < $signed(mv_q.key));
		stat.clr_last = (clr_q == AW'(ITEMS - 1));
		stat.out_free = !out_valid_q || !rsp_stall;
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(ITEMS)) else $error("heap count beyond capacity");
	a_place_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_PLACE |-> (AW + 1)'(s_q) < cnt_w) else $error("placement outside heap");
	a_up_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_UP_MOVE |-> s_q != '0) else $error("sift-up past root");
	a_out_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_OUT |-> !out_valid_q || !rsp_stall) else $error("response overwritten");
endmodule

/* src/imh_ctrl.sv */
module imh_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input imh_pkg::dp_stat_t stat,
	output imh_pkg::dp_cmd_t cmd
);
	import imh_pkg::*;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CHECK, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP,
		S_PLACE, S_CLR, S_DONE
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	// Next state and datapath command
	always_comb begin
		state_d = state_q;
		cmd.op = DP_NONE;
		unique case (state_q)
			S_INIT: begin
				cmd.op = DP_CLR_STEP;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op = DP_ACCEPT;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_DONE;
				unique case (stat.kind)
					KIND_INSERT: begin
						if (!stat.item_ok || !stat.map_unseen || stat.cnt_full) begin
							cmd.op = DP_REJECT;
						end else begin
							cmd.op = DP_INS_START;
							state_d = S_UP_RD;
						end
					end
					KIND_UPDATE: begin
						if (!stat.item_ok || !stat.map_inheap) begin
							cmd.op = DP_REJECT;
						end else begin
							cmd.op = DP_UPD_START;
							state_d = S_UP_RD;
						end
					end
					KIND_EXTRACT: begin
						if (stat.cnt_zero) begin
							cmd.op = DP_EMPTY;
						end else begin
							cmd.op = DP_EX_START;
							if (!stat.ex_last) state_d = S_DN_RD;
						end
					end
					KIND_FINAL: begin
						cmd.op = (!stat.item_ok || stat.map_inheap) ? DP_REJECT : DP_FIN_MARK;
					end
					KIND_CLEAR: begin
						cmd.op = DP_CLR_START;
						state_d = S_CLR;
					end
					default: cmd.op = DP_REJECT;
				endcase
			end
			S_UP_RD: begin
				if (stat.s_zero) begin
					state_d = S_PLACE;
				end else begin
					cmd.op = DP_UP_RD;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_less) begin
					cmd.op = DP_UP_MOVE;
					state_d = S_UP_RD;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_DN_RD: begin
				if (stat.dn_child) begin
					cmd.op = DP_DN_RD;
					state_d = S_DN_CMP;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_DN_CMP: begin
				if (stat.dn_less) begin
					cmd.op = DP_DN_MOVE;
					state_d = S_DN_RD;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.op = DP_PLACE;
				state_d = S_DONE;
			end
			S_CLR: begin
				cmd.op = DP_CLR_STEP;
				if (stat.clr_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.op = DP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_ACCEPT |=> state_q == S_CHECK) else $error("accept not followed by check");
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR && stat.clr_last) |=> state_q == S_DONE) else $error("clear lost");
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_OUT |-> state_q == S_DONE) else $error("stray response");
endmodule
